// ===== src/bmp24d_pkg.sv =====
package bmp24d_pkg;

   // Signature bytes, fixed header values and the first byte after the header.
   localparam logic [7:0]  SIG_B       = 8'h42;
   localparam logic [7:0]  SIG_M       = 8'h4D;
   localparam logic [31:0] HDR_LEN     = 32'd40;
   localparam logic [15:0] PIX_DEPTH   = 16'd24;
   localparam logic [31:0] HDR_END_POS = 32'd32;

   // Result kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   // Error codes.
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_SIGNATURE  = 3'd1;
   localparam logic [2:0] ERR_HDR_LEN    = 3'd2;
   localparam logic [2:0] ERR_DEPTH      = 3'd3;
   localparam logic [2:0] ERR_COMPRESSED = 3'd4;
   localparam logic [2:0] ERR_OFFSET     = 3'd5;
   localparam logic [2:0] ERR_SIZE       = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] pixel_column;
      logic [11:0] pixel_row;
      logic        last_pixel;
      logic [2:0]  error_code;
   } rsp_type;

endpackage

// ===== src/bmp24d_stream_if.sv =====
interface bmp24d_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/bmp24_stream_decoder_core.sv =====
// Streaming decoder for uncompressed 24-bit BMP files. Bytes of the file arrive on req_chan,
// one per item, with start_of_file marking byte 0 of a new file (after reset the block also
// expects byte 0 without it). The header must carry the "BM" signature, a 40-byte info header,
// 24 bits per pixel and a zero compression field; the pixel data offset must be 32 or more and
// the width and height magnitude must lie in 1..MAX_WIDTH and 1..MAX_HEIGHT. Each pixel comes
// out on rsp_chan as one item with red, green and blue, its column and its row in file order
// (bottom-up for a positive height), with last_pixel set on the final one; row padding, the
// gap before the pixel data and bytes after the image produce nothing. A failed check gives
// one error item and the block ignores bytes until the next start_of_file. The decoder takes
// one byte per clock: each byte is decoded in the cycle it is accepted and any result lands in
// a single output register, so req_chan.ready drops only while that register holds a result
// that rsp_chan does not take in the same cycle.
module bmp24_stream_decoder_core
   import bmp24d_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   bmp24d_stream_if.sink          req_chan,
   bmp24d_stream_if.source        rsp_chan
);

   // Counter widths: wide enough to hold the largest legal width or height itself.
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);

   // Parser phases.
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_SKIP   = 3'd1;
   localparam logic [2:0] PH_PIXEL  = 3'd2;
   localparam logic [2:0] PH_PAD    = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;
   localparam logic [2:0] PH_STOP   = 3'd5;

   // Channel slots within one stored pixel (blue, green, then red).
   localparam logic [1:0] CH_BLUE  = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_RED   = 2'd2;

   // Parser state.
   logic [2:0]    phase_ff, phase_in;
   logic [30:0]   byte_pos_ff, byte_pos_in;
   logic [CW-1:0] column_ff, column_in;
   logic [RW-1:0] row_ff, row_in;
   logic [1:0]    chan_ff, chan_in;

   // Header fields and pixel assembly.
   logic [31:0] offset_ff, offset_in;
   logic [23:0] hdr_len_ff, hdr_len_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [15:0] depth_ff, depth_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  pad_ff, pad_in;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Current view of the state: a start of file restarts the parse on this very byte.
   logic          sof;
   logic [7:0]    b;
   logic [2:0]    phase_cur;
   logic [30:0]   byte_pos_cur;
   logic [CW-1:0] column_cur;
   logic [RW-1:0] row_cur;
   logic [1:0]    chan_cur;

   logic          accept;
   logic          emit;
   rsp_type       result;
   logic [30:0]   byte_pos_inc;
   logic [CW-1:0] column_inc;
   logic [RW-1:0] row_inc;
   logic          last;
   logic [31:0]   height_mag;
   logic [1:0]    pad_dec;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   assign sof          = req_chan.payload.start_of_file;
   assign b            = req_chan.payload.data_byte;
   assign phase_cur    = sof ? PH_HEADER : phase_ff;
   assign byte_pos_cur = sof ? '0 : byte_pos_ff;
   assign column_cur   = sof ? '0 : column_ff;
   assign row_cur      = sof ? '0 : row_ff;
   assign chan_cur     = sof ? CH_BLUE : chan_ff;

   assign byte_pos_inc = byte_pos_cur + 31'd1;
   assign column_inc   = column_cur + CW'(1);
   assign row_inc      = row_cur + RW'(1);
   assign last         = (32'(column_inc) == width_ff) && (32'(row_inc) == height_ff);
   assign height_mag   = height_ff[31] ? (32'd0 - height_ff) : height_ff;
   assign pad_dec      = pad_ff - 2'd1;

   always_comb begin
      phase_in    = phase_cur;
      byte_pos_in = byte_pos_cur;
      column_in   = column_cur;
      row_in      = row_cur;
      chan_in     = chan_cur;
      offset_in   = offset_ff;
      hdr_len_in  = hdr_len_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      depth_in    = depth_ff;
      held_in     = held_ff;
      pad_in      = pad_ff;
      emit        = 1'b0;
      result      = '0;

      unique case (phase_cur)
         PH_HEADER: begin
            byte_pos_in = byte_pos_inc;
            // All header byte positions fit in five bits; the phase ends after byte 31.
            unique case (byte_pos_cur[4:0])
               5'd0:  held_in = {8'd0, b};
               5'd1: begin
                  if (held_ff != {8'd0, SIG_B} || b != SIG_M) begin
                     emit              = 1'b1;
                     result.error_code = ERR_SIGNATURE;
                  end
               end
               5'd10: offset_in[7:0]   = b;
               5'd11: offset_in[15:8]  = b;
               5'd12: offset_in[23:16] = b;
               5'd13: offset_in[31:24] = b;
               5'd14: hdr_len_in[7:0]   = b;
               5'd15: hdr_len_in[15:8]  = b;
               5'd16: hdr_len_in[23:16] = b;
               5'd17: begin
                  if ({b, hdr_len_ff} != HDR_LEN) begin
                     emit              = 1'b1;
                     result.error_code = ERR_HDR_LEN;
                  end
               end
               5'd18: width_in[7:0]    = b;
               5'd19: width_in[15:8]   = b;
               5'd20: width_in[23:16]  = b;
               5'd21: width_in[31:24]  = b;
               5'd22: height_in[7:0]   = b;
               5'd23: height_in[15:8]  = b;
               5'd24: height_in[23:16] = b;
               5'd25: height_in[31:24] = b;
               5'd28: depth_in[7:0]    = b;
               5'd29: depth_in[15:8]   = b;
               5'd30: held_in = {8'd0, b};
               5'd31: begin
                  // Checks in order of precedence: depth, compression, offset, size.
                  priority if (depth_ff != PIX_DEPTH) begin
                     emit              = 1'b1;
                     result.error_code = ERR_DEPTH;
                  end else if (held_ff != 16'd0 || b != 8'd0) begin
                     emit              = 1'b1;
                     result.error_code = ERR_COMPRESSED;
                  end else if (offset_ff[31] || offset_ff < HDR_END_POS) begin
                     emit              = 1'b1;
                     result.error_code = ERR_OFFSET;
                  end else if (width_ff == 32'd0 || width_ff[31] ||
                               width_ff > 32'(MAX_WIDTH) ||
                               height_mag == 32'd0 || height_mag > 32'(MAX_HEIGHT)) begin
                     emit              = 1'b1;
                     result.error_code = ERR_SIZE;
                  end else begin
                     height_in = height_mag;
                     phase_in  = (offset_ff == HDR_END_POS) ? PH_PIXEL : PH_SKIP;
                  end
               end
               default: ;
            endcase
            if (emit) begin
               result.result_kind = KIND_ERROR;
               phase_in           = PH_STOP;
            end
         end

         PH_SKIP: begin
            // Drop bytes up to the pixel data offset, which is known to be above 32 here.
            byte_pos_in = byte_pos_inc;
            if (byte_pos_inc == offset_ff[30:0]) begin
               phase_in = PH_PIXEL;
            end
         end

         PH_PIXEL: begin
            unique case (chan_cur)
               CH_BLUE: begin
                  held_in = {8'd0, b};
                  chan_in = CH_GREEN;
               end
               CH_GREEN: begin
                  held_in = {b, held_ff[7:0]};
                  chan_in = CH_RED;
               end
               default: begin
                  emit                = 1'b1;
                  chan_in             = CH_BLUE;
                  result.result_kind  = KIND_PIXEL;
                  result.red          = b;
                  result.green        = held_ff[15:8];
                  result.blue         = held_ff[7:0];
                  result.pixel_column = 12'(column_cur);
                  result.pixel_row    = 12'(row_cur);
                  result.last_pixel   = last;
                  result.error_code   = ERR_NONE;
                  column_in           = column_inc;
                  if (32'(column_inc) == width_ff) begin
                     column_in = '0;
                     row_in    = row_inc;
                     if (last) begin
                        phase_in = PH_DONE;
                     end else if (width_ff[1:0] != 2'd0) begin
                        // Three bytes a pixel leave width mod 4 bytes of padding per row.
                        pad_in   = width_ff[1:0];
                        phase_in = PH_PAD;
                     end
                  end
               end
            endcase
         end

         PH_PAD: begin
            pad_in = pad_dec;
            if (pad_dec == 2'd0) begin
               phase_in = PH_PIXEL;
            end
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         byte_pos_ff <= '0;
         column_ff   <= '0;
         row_ff      <= '0;
         chan_ff     <= CH_BLUE;
      end else if (accept) begin
         phase_ff    <= phase_in;
         byte_pos_ff <= byte_pos_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
         chan_ff     <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         offset_ff  <= offset_in;
         hdr_len_ff <= hdr_len_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         held_ff    <= held_in;
         pad_ff     <= pad_in;
      end
   end

   // The output register refills in the same cycle it is emptied.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // An error item always carries a nonzero code and no pixel data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.payload.result_kind == KIND_ERROR) |->
         (rsp_chan.payload.error_code != ERR_NONE && rsp_chan.payload.last_pixel == 1'b0))
      else $error("error item without code or with pixel flag");

   // Any error stops the parse until the next start of file.
   assert property (@(posedge clock) disable iff (reset)
      (accept && emit && result.result_kind == KIND_ERROR) |=> (phase_ff == PH_STOP))
      else $error("parser did not stop after an error");

   // The final pixel of an image leaves the parser in the done phase.
   assert property (@(posedge clock) disable iff (reset)
      (accept && emit && result.last_pixel) |=> (phase_ff == PH_DONE))
      else $error("parser not done after last pixel");

   // While reading pixels, the column stays inside the row and the channel slot is legal.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PIXEL) |-> (32'(column_ff) < width_ff && chan_ff <= CH_RED))
      else $error("pixel column or channel slot out of range");

endmodule
